// File: src/bcfc_pkg.sv
// Package for the block CRC frame checker.
// Holds the CRC constants, block geometry, status codes and the register map.
// No dependencies.
`default_nettype none

package bcfc_pkg;

  localparam logic [15:0] CRC_POLY = 16'h3D65;
  localparam logic [15:0] CRC_XOR  = 16'hFFFF;

  localparam int FIRST_BLK_DATA = 10;
  localparam int FIRST_BLK_RAW  = 12;
  localparam int FULL_BLK_DATA  = 16;
  localparam int FULL_BLK_RAW   = 18;
  localparam int CRC_BYTES      = 2;

  localparam int POS_W  = 9;
  localparam int FILL_W = 5;
  localparam int CAP_W  = 9;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_PAYLOAD_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SHORT    = 2'd1,
    STAT_CRC      = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  // Raw frame length, CRC bytes included, fixed by the length field.
  function automatic logic [POS_W-1:0] frame_need(input logic [7:0] len);
    logic [7:0] rest;
    logic [3:0] full;
    logic [3:0] tail;
    logic [POS_W-1:0] need;
    rest = len - 8'd9;
    full = rest[7:4];
    tail = rest[3:0];
    need = POS_W'(FIRST_BLK_RAW) + {1'b0, full, 4'b0000} + {4'b0000, full, 1'b0};
    if (tail != 4'd0) begin
      need = need + {5'b00000, tail} + POS_W'(CRC_BYTES);
    end
    if (len <= 8'd9) begin
      need = POS_W'(FIRST_BLK_RAW);
    end
    return need;
  endfunction

endpackage

`default_nettype wire

// File: src/bcfc_in_if.sv
// Input channel of the block CRC frame checker: one raw frame byte per request.
// Depends on nothing.
`default_nettype none

interface bcfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// File: src/bcfc_out_if.sv
// Result channel of the block CRC frame checker: data bytes and frame status.
// Depends on bcfc_pkg for the status type and widths.
`default_nettype none

interface bcfc_out_if;
  import bcfc_pkg::*;

  logic             valid;
  logic             ready;
  logic             is_status;
  logic [7:0]       data_byte;
  status_t          status_code;
  logic [CAP_W-1:0] payload_length;
  logic             run_last;

  modport source (output valid, output is_status, output data_byte, output status_code,
                  output payload_length, output run_last, input ready);
  modport sink (input valid, input is_status, input data_byte, input status_code,
                input payload_length, input run_last, output ready);
endinterface

`default_nettype wire

// File: src/block_crc_frame_checker.sv
// Top level of the block CRC frame checker with per-block CRC-16 and capacity check.
// Depends on bcfc_pkg, bcfc_in_if and bcfc_out_if.
//
//   channel      | kind         | carries
//   frame_in     | valid/ready  | frame_byte, frame_end
//   result_out   | valid/ready  | is_status, data_byte, status_code, payload_length, run_last
//   APB          | psel/penable | payload_capacity at address 0
//
// Each byte passes through S_IDLE and S_PROC; a data byte then enters S_CRC, where the
// CRC runs one bit per cycle through a single shift-and-xor unit. A passing CRC byte
// drains the buffered data bytes, and frame end adds a status request.
// Reset is synchronous; the block buffer is not cleared. A stalled result
// register holds the sequencer in place until the request is taken.
`default_nettype none

module block_crc_frame_checker (
  input  wire                             clk,
  input  wire                             rst,
  bcfc_in_if.sink                         frame_in,
  bcfc_out_if.source                      result_out,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [bcfc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire [bcfc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bcfc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bcfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROC,
    S_CRC,
    S_DRAIN,
    S_STATUS
  } state_t;

  state_t           state;
  logic [CAP_W-1:0] payload_capacity;
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] need;
  logic [FILL_W-1:0] block_fill;
  logic [FILL_W-1:0] blk;
  logic [15:0]      running_crc;
  logic [7:0]       received_crc_high;
  logic [7:0]       block_buffer [FULL_BLK_DATA];
  logic [CAP_W-1:0] emitted_count;
  status_t          error_state;
  logic [7:0]       cur_byte;
  logic             cur_end;
  logic [2:0]       bit_count;
  logic [3:0]       drain_index;

  logic             out_valid;
  logic             out_is_status;
  logic [7:0]       out_data;
  status_t          out_code;
  logic [CAP_W-1:0] out_length;
  logic             out_last;

  logic             cfg_write;
  logic             out_free;
  logic             out_load;
  logic             in_range;
  logic [POS_W-1:0] block_start;
  logic [POS_W-1:0] remain;
  logic [FILL_W-1:0] blk_next;
  logic [CAP_W:0]   emitted_sum;
  status_t          frame_code;
  state_t           done_state;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_PAYLOAD_CAPACITY) ?
                     {{(APB_DATA_W-CAP_W){1'b0}}, payload_capacity} : '0;

  assign frame_in.ready           = (state == S_IDLE);
  assign result_out.valid         = out_valid;
  assign result_out.is_status     = out_is_status;
  assign result_out.data_byte     = out_data;
  assign result_out.status_code   = out_code;
  assign result_out.payload_length = out_length;
  assign result_out.run_last      = out_last;

  assign out_free = !out_valid || result_out.ready;
  assign out_load = out_free && (state == S_DRAIN || state == S_STATUS);

  always_comb begin
    in_range    = byte_position < need;
    block_start = byte_position - {{(POS_W-FILL_W){1'b0}}, block_fill};
    remain      = need - block_start;
    if (byte_position < POS_W'(FIRST_BLK_RAW)) begin
      blk_next = FILL_W'(FIRST_BLK_DATA);
    end else if (remain >= POS_W'(FULL_BLK_RAW) || remain < POS_W'(CRC_BYTES)) begin
      blk_next = FILL_W'(FULL_BLK_DATA);
    end else begin
      blk_next = FILL_W'(remain - POS_W'(CRC_BYTES));
    end
    emitted_sum = {1'b0, emitted_count} + {{(CAP_W+1-FILL_W){1'b0}}, blk};
    frame_code  = (byte_position < need) ? STAT_SHORT : error_state;
    done_state  = cur_end ? S_STATUS : S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      payload_capacity  <= CAPACITY_RESET;
      byte_position     <= '0;
      need              <= POS_W'(FIRST_BLK_RAW);
      block_fill        <= '0;
      blk               <= '0;
      running_crc       <= '0;
      received_crc_high <= '0;
      emitted_count     <= '0;
      error_state       <= STAT_OK;
      cur_byte          <= '0;
      cur_end           <= 1'b0;
      bit_count         <= '0;
      drain_index       <= '0;
      out_valid         <= 1'b0;
      out_is_status     <= 1'b0;
      out_data          <= '0;
      out_code          <= STAT_OK;
      out_length        <= '0;
      out_last          <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == REG_PAYLOAD_CAPACITY) begin
        payload_capacity <= pwdata[CAP_W-1:0];
      end
      if (out_valid && result_out.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (frame_in.valid) begin
            cur_byte <= frame_in.frame_byte;
            cur_end  <= frame_in.frame_end;
            if (byte_position == '0) begin
              need <= frame_need(frame_in.frame_byte);
            end
            state <= S_PROC;
          end
        end

        S_PROC: begin
          if (in_range) begin
            blk           <= blk_next;
            byte_position <= byte_position + POS_W'(1);
            if (block_fill < blk_next) begin
              block_buffer[block_fill[3:0]] <= cur_byte;
              running_crc <= running_crc ^ {cur_byte, 8'h00};
              block_fill  <= block_fill + FILL_W'(1);
              bit_count   <= '0;
              state       <= S_CRC;
            end else if (block_fill == blk_next) begin
              received_crc_high <= cur_byte;
              block_fill        <= block_fill + FILL_W'(1);
              state             <= done_state;
            end else begin
              block_fill  <= '0;
              running_crc <= '0;
              if (error_state != STAT_OK) begin
                state <= done_state;
              end else if ((running_crc ^ CRC_XOR) != {received_crc_high, cur_byte}) begin
                error_state <= STAT_CRC;
                state       <= done_state;
              end else if ({1'b0, emitted_count} +
                           {{(CAP_W+1-FILL_W){1'b0}}, blk_next} >
                           {1'b0, payload_capacity}) begin
                error_state <= STAT_OVERFLOW;
                state       <= done_state;
              end else begin
                drain_index <= '0;
                state       <= S_DRAIN;
              end
            end
          end else begin
            state <= done_state;
          end
        end

        S_CRC: begin
          running_crc <= running_crc[15] ? ({running_crc[14:0], 1'b0} ^ CRC_POLY)
                                         : {running_crc[14:0], 1'b0};
          bit_count   <= bit_count + 3'd1;
          if (bit_count == 3'd7) begin
            state <= done_state;
          end
        end

        S_DRAIN: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_is_status <= 1'b0;
            out_data      <= block_buffer[drain_index];
            out_code      <= STAT_OK;
            out_length    <= '0;
            out_last      <= ({1'b0, drain_index} == blk - FILL_W'(1)) && !cur_end;
            drain_index   <= drain_index + 4'd1;
            if ({1'b0, drain_index} == blk - FILL_W'(1)) begin
              emitted_count <= emitted_sum[CAP_W-1:0];
              state         <= done_state;
            end
          end
        end

        S_STATUS: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_is_status     <= 1'b1;
            out_data          <= '0;
            out_code          <= frame_code;
            out_length        <= (frame_code == STAT_OK) ? emitted_count : '0;
            out_last          <= 1'b1;
            byte_position     <= '0;
            need              <= POS_W'(FIRST_BLK_RAW);
            block_fill        <= '0;
            running_crc       <= '0;
            received_crc_high <= '0;
            emitted_count     <= '0;
            error_state       <= STAT_OK;
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
